// ----- rtl/core/tdl_pkg.sv -----
// Shared types, constants and helpers of the TD critic core.
package tdl_pkg;

   localparam int NUM_FEATURES   = 8;
   localparam int WEIGHT_ENTRIES = 4096;
   localparam int TRACE_DEPTH    = 8;
   localparam int QUEUE_DEPTH    = 4;

   localparam int IDX_W   = 12;
   localparam int WADDR_W = $clog2(WEIGHT_ENTRIES);
   localparam int POS_W   = $clog2(NUM_FEATURES);
   localparam int CNT_W   = $clog2(NUM_FEATURES + 1);
   localparam int SLOT_W  = (TRACE_DEPTH > 1) ? $clog2(TRACE_DEPTH) : 1;
   localparam int FILL_W  = $clog2(TRACE_DEPTH + 1);
   localparam int QPTR_W  = $clog2(QUEUE_DEPTH);

   localparam logic [1:0] CSR_DISCOUNT    = 2'd0;
   localparam logic [1:0] CSR_LEARN_RATE  = 2'd1;
   localparam logic [1:0] CSR_TRACE_DECAY = 2'd2;

   localparam logic [15:0] DISCOUNT_RST    = 16'd64880;
   localparam logic [15:0] LEARN_RATE_RST  = 16'd655;
   localparam logic [15:0] TRACE_DECAY_RST = 16'd58982;

   typedef enum logic [1:0] {
      OP_SCALE = 2'd0,
      OP_FEAT  = 2'd1,
      OP_LAST  = 2'd2
   } op_type;

   typedef struct packed {
      op_type                   op;
      logic [2:0]               position;
      logic signed [15:0]       scale_value;
      logic [IDX_W-1:0]         feature_index;
      logic signed [31:0]       reward;
      logic                     terminal;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } queue_head_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_ctl_type;

   typedef logic [NUM_FEATURES-1:0][IDX_W-1:0] feat_row_type;

   function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
      if (x > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return x[31:0];
   endfunction

endpackage

// ----- rtl/core/td_lambda_linear_critic_core.sv -----
// Top level of the TD(lambda) linear critic core.
// The req_ channel carries one transaction per feature index (cmd 0) or per
// position scale load (cmd 1). A feature transaction with last_feature set
// closes the new state: the core then sums the old and new values, forms
// the TD error, pushes the old feature vector into the trace and updates
// the weights before one result leaves on the rsp_ channel.
// Transactions enter a four-entry queue, so loads and features are taken
// one per cycle while the back end is still busy, until the queue is full.
// A scale load or a plain feature is retired without leaving the idle state.
// A terminal new state is valued zero and not summed. The weight store has
// one read and one write port: each weight is read, multiplied and written
// back in turn.
// After reset the core sweeps all 4096 weights to zero, one per cycle, with
// req_stall held high; configuration writes are taken throughout.
// A result waits in an output register while rsp_stall is high; the back
// end holds its commit until that register is free.
module td_lambda_linear_critic_core
   import tdl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [2:0]         req_position,
   input  logic signed [15:0] req_scale_value,
   input  logic [11:0]        req_feature_index,
   input  logic signed [31:0] req_reward,
   input  logic               req_terminal,
   input  logic               req_last_feature,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value_error
);

   queue_head_type head;
   back_ctl_type   ctl;

   tdl_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_position      (req_position),
      .req_scale_value   (req_scale_value),
      .req_feature_index (req_feature_index),
      .req_reward        (req_reward),
      .req_terminal      (req_terminal),
      .req_last_feature  (req_last_feature),
      .ctl               (ctl),
      .head              (head)
   );

   tdl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .head            (head),
      .ctl             (ctl),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_value_error (rsp_value_error)
   );

endmodule

// ----- rtl/core/tdl_front.sv -----
// Front end: classifies accepted transactions and queues them for the back end.
module tdl_front
   import tdl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic               req_cmd,
   input  logic [2:0]         req_position,
   input  logic signed [15:0] req_scale_value,
   input  logic [11:0]        req_feature_index,
   input  logic signed [31:0] req_reward,
   input  logic               req_terminal,
   input  logic               req_last_feature,
   input  back_ctl_type       ctl,
   output queue_head_type     head
);

   item_type           q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]  wp_ff, wp_in, rp_ff, rp_in;
   logic [QPTR_W:0]    cnt_ff, cnt_in;
   logic               push, pop;
   item_type           cls;

   assign req_stall = ctl.clearing || (cnt_ff == (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign pop       = ctl.pop && (cnt_ff != '0);

   always_comb begin
      cls.position      = req_position;
      cls.scale_value   = req_scale_value;
      cls.feature_index = req_feature_index;
      cls.reward        = req_reward;
      cls.terminal      = req_terminal;
      if (req_cmd) begin
         cls.op = OP_SCALE;
      end else if (req_last_feature) begin
         cls.op = OP_LAST;
      end else begin
         cls.op = OP_FEAT;
      end
   end

   always_comb begin
      wp_in  = push ? wp_ff + 1'b1 : wp_ff;
      rp_in  = pop  ? rp_ff + 1'b1 : rp_ff;
      cnt_in = cnt_ff + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wp_ff] <= cls;
      end
   end

   assign head.valid = (cnt_ff != '0);
   assign head.item  = q_ff[rp_ff];

endmodule

// ----- rtl/core/tdl_back.sv -----
// Back end: weight store, value sums, TD error, trace and weight update sequencer.
module tdl_back
   import tdl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [15:0]        csr_wdata,
   input  queue_head_type     head,
   output back_ctl_type       ctl,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [31:0] rsp_value_error
);

   typedef enum logic [10:0] {
      S_CLEAR  = 11'b00000000001,
      S_IDLE   = 11'b00000000010,
      S_VRD    = 11'b00000000100,
      S_VMUL   = 11'b00000001000,
      S_VACC   = 11'b00000010000,
      S_GAM    = 11'b00000100000,
      S_TD     = 11'b00001000000,
      S_DLT    = 11'b00010000000,
      S_URD    = 11'b00100000000,
      S_UMUL   = 11'b01000000000,
      S_UWR    = 11'b10000000000
   } state_type;

   // Weight store with one write and one registered read port.
   logic signed [31:0] mem [WEIGHT_ENTRIES];
   logic signed [31:0] rd_data_ff;
   logic [WADDR_W-1:0] rd_addr, wr_addr;
   logic signed [31:0] wr_data;
   logic               wr_en;

   state_type          state_ff, state_in;
   logic [15:0]        disc_ff, disc_in, alpha_ff, alpha_in, decay_ff, decay_in;
   logic signed [15:0] scale_ff [NUM_FEATURES];
   logic signed [15:0] scale_in [NUM_FEATURES];
   feat_row_type       cur_ff, cur_in, inc_ff, inc_in;
   logic [CNT_W-1:0]   cur_len_ff, cur_len_in, load_ff, load_in;
   feat_row_type       row_ff [TRACE_DEPTH];
   logic [CNT_W-1:0]   len_ff [TRACE_DEPTH];
   logic               push_trace;
   logic [SLOT_W-1:0]  head_ff, head_in, slot, next_head;
   logic [FILL_W-1:0]  fill_ff, fill_in, k_ff, k_in;
   logic [CNT_W-1:0]   i_ff, i_in, len_sel;
   logic               phase_ff, phase_in, term_ff, term_in;
   logic signed [31:0] reward_ff, reward_in;
   logic signed [50:0] acc_ff, acc_in, acc_r;
   logic signed [48:0] prod_ff, prod_in, gprod_ff, gprod_in, dprod_ff, dprod_in;
   logic signed [48:0] g_r, d_r, u_r;
   logic signed [49:0] dd, dd_r;
   logic signed [31:0] old_v_ff, old_v_in, new_v_ff, new_v_in, td_ff, td_in;
   logic signed [32:0] delta_ff, delta_in;
   logic signed [34:0] t_sum;
   logic [WADDR_W-1:0] clr_ff, clr_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic signed [31:0] rsp_td_ff, rsp_td_in;
   logic               out_free;

   assign acc_r   = (acc_ff + 51'sd2048) >>> 12;
   assign g_r     = (gprod_ff + 49'sd32768) >>> 16;
   assign d_r     = (dprod_ff + 49'sd32768) >>> 16;
   assign u_r     = (prod_ff + 49'sd2048) >>> 12;
   assign dd      = 50'(delta_ff) * $signed({34'd0, decay_ff});
   assign dd_r    = (dd + 50'sd32768) >>> 16;
   assign t_sum   = 35'(reward_ff) + 35'(g_r) - 35'(old_v_ff);
   assign slot    = head_ff - SLOT_W'(k_ff);
   assign next_head = (head_ff == SLOT_W'(TRACE_DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign len_sel = phase_ff ? load_ff : cur_len_ff;
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in    = state_ff;
      disc_in     = disc_ff;
      alpha_in    = alpha_ff;
      decay_in    = decay_ff;
      scale_in    = scale_ff;
      cur_in      = cur_ff;
      cur_len_in  = cur_len_ff;
      inc_in      = inc_ff;
      load_in     = load_ff;
      head_in     = head_ff;
      fill_in     = fill_ff;
      k_in        = k_ff;
      i_in        = i_ff;
      phase_in    = phase_ff;
      term_in     = term_ff;
      reward_in   = reward_ff;
      acc_in      = acc_ff;
      prod_in     = prod_ff;
      gprod_in    = gprod_ff;
      dprod_in    = dprod_ff;
      old_v_in    = old_v_ff;
      new_v_in    = new_v_ff;
      td_in       = td_ff;
      delta_in    = delta_ff;
      clr_in      = clr_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_td_in   = rsp_td_ff;
      push_trace  = 1'b0;
      ctl.pop     = 1'b0;
      ctl.clearing = (state_ff == S_CLEAR);
      wr_en       = 1'b0;
      wr_addr     = clr_ff;
      wr_data     = '0;
      rd_addr     = '0;

      if (csr_we) begin
         case (csr_index)
            CSR_DISCOUNT:    disc_in  = csr_wdata;
            CSR_LEARN_RATE:  alpha_in = csr_wdata;
            CSR_TRACE_DECAY: decay_in = csr_wdata;
            default: ;
         endcase
      end

      case (state_ff)
         S_CLEAR: begin
            wr_en  = 1'b1;
            clr_in = clr_ff + 1'b1;
            if (clr_ff == '1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (head.valid) begin
               ctl.pop = 1'b1;
               if (head.item.op == OP_SCALE) begin
                  if (32'(head.item.position) < NUM_FEATURES) begin
                     scale_in[POS_W'(head.item.position)] = head.item.scale_value;
                  end
               end else begin
                  if (load_ff < CNT_W'(NUM_FEATURES)) begin
                     inc_in[POS_W'(load_ff)] = head.item.feature_index;
                     load_in = load_ff + 1'b1;
                  end
                  if (head.item.op == OP_LAST) begin
                     reward_in = head.item.reward;
                     term_in   = head.item.terminal;
                     phase_in  = 1'b0;
                     i_in      = '0;
                     acc_in    = '0;
                     state_in  = S_VRD;
                  end
               end
            end
         end
         S_VRD: begin
            if (i_ff == len_sel) begin
               acc_in = '0;
               i_in   = '0;
               if (!phase_ff) begin
                  old_v_in = sat32(64'(acc_r));
                  phase_in = 1'b1;
                  if (term_ff) begin
                     new_v_in = '0;
                     state_in = S_GAM;
                  end
               end else begin
                  new_v_in = sat32(64'(acc_r));
                  state_in = S_GAM;
               end
            end else begin
               rd_addr  = WADDR_W'(phase_ff ? inc_ff[POS_W'(i_ff)] : cur_ff[POS_W'(i_ff)]);
               state_in = S_VMUL;
            end
         end
         S_VMUL: begin
            prod_in  = 49'(rd_data_ff) * 49'(scale_ff[POS_W'(i_ff)]);
            state_in = S_VACC;
         end
         S_VACC: begin
            acc_in   = acc_ff + 51'(prod_ff);
            i_in     = i_ff + 1'b1;
            state_in = S_VRD;
         end
         S_GAM: begin
            gprod_in = 49'(new_v_ff) * $signed({33'd0, disc_ff});
            state_in = S_TD;
         end
         S_TD: begin
            td_in      = sat32(64'(t_sum));
            push_trace = 1'b1;
            head_in    = next_head;
            if (fill_ff != FILL_W'(TRACE_DEPTH)) begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = S_DLT;
         end
         S_DLT: begin
            dprod_in = 49'(td_ff) * $signed({33'd0, alpha_ff});
            k_in     = '0;
            i_in     = '0;
            delta_in = '0;
            state_in = S_URD;
            // The update starts with a wait for the registered product.
            phase_in = 1'b0;
         end
         S_URD: begin
            if (!phase_ff) begin
               delta_in = 33'(d_r);
               phase_in = 1'b1;
            end else if (k_ff == fill_ff) begin
               if (out_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_td_in    = td_ff;
                  for (int n = 0; n < NUM_FEATURES; n++) begin
                     cur_in[n] = (CNT_W'(n) < load_ff) ? inc_ff[n] : '0;
                  end
                  cur_len_in = load_ff;
                  load_in    = '0;
                  state_in   = S_IDLE;
               end
            end else if (i_ff == len_ff[slot]) begin
               delta_in = 33'(dd_r);
               k_in     = k_ff + 1'b1;
               i_in     = '0;
            end else begin
               rd_addr  = WADDR_W'(row_ff[slot][POS_W'(i_ff)]);
               state_in = S_UMUL;
            end
         end
         S_UMUL: begin
            // The read address is held so that the weight is still on the read port.
            rd_addr  = WADDR_W'(row_ff[slot][POS_W'(i_ff)]);
            prod_in  = 49'(delta_ff) * 49'(scale_ff[POS_W'(i_ff)]);
            state_in = S_UWR;
         end
         S_UWR: begin
            wr_en    = 1'b1;
            wr_addr  = WADDR_W'(row_ff[slot][POS_W'(i_ff)]);
            wr_data  = sat32(64'(rd_data_ff) + 64'(u_r));
            i_in     = i_ff + 1'b1;
            state_in = S_URD;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         disc_ff      <= DISCOUNT_RST;
         alpha_ff     <= LEARN_RATE_RST;
         decay_ff     <= TRACE_DECAY_RST;
         for (int n = 0; n < NUM_FEATURES; n++) begin
            scale_ff[n] <= '0;
         end
         cur_ff       <= '0;
         cur_len_ff   <= CNT_W'(NUM_FEATURES);
         load_ff      <= '0;
         head_ff      <= '0;
         fill_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         disc_ff      <= disc_in;
         alpha_ff     <= alpha_in;
         decay_ff     <= decay_in;
         scale_ff     <= scale_in;
         cur_ff       <= cur_in;
         cur_len_ff   <= cur_len_in;
         load_ff      <= load_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      inc_ff    <= inc_in;
      k_ff      <= k_in;
      i_ff      <= i_in;
      phase_ff  <= phase_in;
      term_ff   <= term_in;
      reward_ff <= reward_in;
      acc_ff    <= acc_in;
      prod_ff   <= prod_in;
      gprod_ff  <= gprod_in;
      dprod_ff  <= dprod_in;
      old_v_ff  <= old_v_in;
      new_v_ff  <= new_v_in;
      td_ff     <= td_in;
      delta_ff  <= delta_in;
      rsp_td_ff <= rsp_td_in;
      if (push_trace) begin
         row_ff[next_head] <= cur_ff;
         len_ff[next_head] <= cur_len_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_value_error = rsp_td_ff;

   a_no_pop_in_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clearing |-> !ctl.pop)
      else $error("queue popped during weight clearing");

   a_no_rsp_in_clear: assert property (@(posedge clock) disable iff (reset)
      ctl.clearing |-> !rsp_valid_ff)
      else $error("result shown during weight clearing");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(TRACE_DEPTH))
      else $error("trace fill beyond depth");

   a_load_bound: assert property (@(posedge clock) disable iff (reset)
      load_ff <= CNT_W'(NUM_FEATURES))
      else $error("feature count beyond vector length");

   a_rsp_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == S_URD))
      else $error("result raised outside the commit step");

endmodule

// ----- tb/td_lambda_linear_critic_core_test.sv -----
// Self-checking testbench for the TD(lambda) linear critic core.
`timescale 1ns / 100ps

module td_lambda_linear_critic_core_test;
   import tdl_pkg::*;

   logic               clock;
   logic               reset;
   logic               csr_we;
   logic [1:0]         csr_index;
   logic [15:0]        csr_wdata;
   logic               req_valid;
   logic               req_stall;
   logic               req_cmd;
   logic [2:0]         req_position;
   logic signed [15:0] req_scale_value;
   logic [11:0]        req_feature_index;
   logic signed [31:0] req_reward;
   logic               req_terminal;
   logic               req_last_feature;
   logic               rsp_valid;
   logic               rsp_stall;
   logic signed [31:0] rsp_value_error;

   td_lambda_linear_critic_core DUT (.*);

   // Predicted state of the critic.
   logic [15:0] gamma_q, alpha_q, falloff_q;
   int          weights [WEIGHT_ENTRIES];
   int          scales [NUM_FEATURES];
   logic [11:0] cur_feats [NUM_FEATURES];
   int          cur_len;
   logic [11:0] new_feats [NUM_FEATURES];
   int          new_len;
   logic [11:0] trace_feats [TRACE_DEPTH][NUM_FEATURES];
   int          trace_lengths [TRACE_DEPTH];
   int          trace_newest;
   int          trace_count;

   int expected_errors [$];
   int mismatches;
   int failures;
   int items_sent;
   bit idling;

   initial begin
      clock = 1'b0;
   end
   always #5 clock = ~clock;

   function automatic longint round_half_up(longint x, int s);
      return (x + (64'sd1 <<< (s - 1))) >>> s;
   endfunction

   function automatic int clamp_q816(longint x);
      if (x > 64'sd2147483647) begin
         return 32'sh7fffffff;
      end else if (x < -64'sd2147483648) begin
         return 32'sh80000000;
      end
      return int'(x);
   endfunction

   function automatic int state_value(logic [11:0] feats [NUM_FEATURES], int len);
      longint acc;
      acc = 0;
      for (int i = 0; i < len; i++) begin
         acc += longint'(weights[feats[i]]) * longint'(scales[i]);
      end
      return clamp_q816(round_half_up(acc, 12));
   endfunction

   task automatic predict_csr(logic [1:0] idx, logic [15:0] value);
      case (idx)
         CSR_DISCOUNT: begin
            gamma_q = value;
         end
         CSR_LEARN_RATE: begin
            alpha_q = value;
         end
         CSR_TRACE_DECAY: begin
            falloff_q = value;
         end
         default: begin
         end
      endcase
   endtask

   // Works out the effect of one accepted transaction and queues any error.
   task automatic predict_transaction(bit cmd, logic [2:0] pos, logic signed [15:0] sc,
                                      logic [11:0] idx, int rew, bit term, bit last);
      int     old_v, new_v, td, slot;
      longint t, delta, inc;
      if (cmd) begin
         scales[pos] = sc;
         return;
      end
      if (new_len < NUM_FEATURES) begin
         new_feats[new_len] = idx;
         new_len++;
      end
      if (!last) begin
         return;
      end
      old_v = state_value(cur_feats, cur_len);
      new_v = term ? 0 : state_value(new_feats, new_len);
      t = longint'(rew) + round_half_up(longint'(gamma_q) * new_v, 16) - old_v;
      td = clamp_q816(t);
      trace_newest = (trace_newest + 1) % TRACE_DEPTH;
      trace_feats[trace_newest] = cur_feats;
      trace_lengths[trace_newest] = cur_len;
      if (trace_count < TRACE_DEPTH) begin
         trace_count++;
      end
      delta = round_half_up(longint'(alpha_q) * td, 16);
      for (int k = 0; k < trace_count; k++) begin
         slot = (trace_newest + TRACE_DEPTH - k) % TRACE_DEPTH;
         for (int j = 0; j < trace_lengths[slot]; j++) begin
            inc = round_half_up(delta * scales[j], 12);
            weights[trace_feats[slot][j]] =
               clamp_q816(longint'(weights[trace_feats[slot][j]]) + inc);
         end
         delta = round_half_up(delta * longint'(falloff_q), 16);
      end
      for (int i = 0; i < NUM_FEATURES; i++) begin
         cur_feats[i] = (i < new_len) ? new_feats[i] : 12'd0;
      end
      cur_len = new_len;
      new_len = 0;
      expected_errors.push_back(td);
   endtask

   task automatic send_item(bit cmd, logic [2:0] pos, logic signed [15:0] sc,
                            logic [11:0] idx, int rew, bit term, bit last);
      @(negedge clock);
      while (idling && $urandom_range(99) < 11) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_cmd <= cmd;
      req_position <= pos;
      req_scale_value <= sc;
      req_feature_index <= idx;
      req_reward <= rew;
      req_terminal <= term;
      req_last_feature <= last;
      req_valid <= 1'b1;
      do begin
         @(posedge clock);
      end while (req_stall);
      items_sent++;
      predict_transaction(cmd, pos, sc, idx, rew, term, last);
   endtask

   // Lowers valid and lets the core drain before any register write.
   task automatic drain;
      @(negedge clock);
      req_valid <= 1'b0;
      wait (expected_errors.size() == 0);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_csr(logic [1:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we <= 1'b0;
      predict_csr(idx, value);
   endtask

   task automatic feature(logic [11:0] idx);
      send_item(1'b0, 3'($urandom), 16'($urandom), idx, $urandom, 1'($urandom), 1'b0);
   endtask

   task automatic close_state(logic [11:0] idx, int rew, bit term);
      send_item(1'b0, 3'($urandom), 16'($urandom), idx, rew, term, 1'b1);
   endtask

   task automatic test_scale_loads;
      send_item(1'b1, 3'd0, 16'sh7fff, 12'd0, 0, 1'b0, 1'b0);
      send_item(1'b1, 3'd7, -16'sh8000, 12'hfff, 0, 1'b0, 1'b0);
      send_item(1'b1, 3'd1, 16'sh1000, 12'd0, 0, 1'b0, 1'b0);
      // A scale load carrying a last mark gives no result.
      send_item(1'b1, 3'd2, -16'sh0800, 12'd5, 32'sh7fffffff, 1'b1, 1'b1);
      drain();
   endtask

   task automatic test_directed_states;
      feature(12'd0);
      close_state(12'hfff, 32'sh7fffffff, 1'b0);
      feature(12'd3);
      feature(12'd3);
      close_state(12'd3, 32'sh80000000, 1'b0);
      // Ten features: the two beyond the vector length are dropped.
      for (int i = 0; i < 9; i++) begin
         feature(12'(i * 455));
      end
      close_state(12'd9, 32'sh00010000, 1'b1);
      close_state(12'hfff, -32'sh00020000, 1'b0);
      drain();
   endtask

   task automatic test_random_states(int target);
      int          n;
      logic [11:0] idx;
      int          rew;
      while (items_sent < target) begin
         if ($urandom_range(99) < 25) begin
            send_item(1'b1, 3'($urandom), 16'($urandom), 12'($urandom), $urandom,
                      1'($urandom), 1'($urandom));
         end
         n = ($urandom_range(99) < 10) ? $urandom_range(9, 11) : $urandom_range(1, 8);
         for (int i = 0; i < n; i++) begin
            idx = ($urandom_range(99) < 80) ? 12'($urandom_range(0, 23)) : 12'($urandom);
            rew = ($urandom_range(99) < 70) ? $signed($urandom_range(0, 32'h3ffff)) - 32'h20000
                                              : $urandom;
            send_item(1'b0, 3'($urandom), 16'($urandom), idx, rew, $urandom_range(99) < 12,
                      i == n - 1);
         end
      end
      drain();
   endtask

   task automatic test_register_settings;
      write_csr(CSR_DISCOUNT, 16'hffff);
      write_csr(CSR_LEARN_RATE, 16'hffff);
      write_csr(CSR_TRACE_DECAY, 16'hffff);
      test_random_states(items_sent + 150);
      write_csr(CSR_DISCOUNT, 16'h0000);
      write_csr(CSR_LEARN_RATE, 16'h0000);
      write_csr(CSR_TRACE_DECAY, 16'h0000);
      // The unused register index must have no effect.
      write_csr(2'd3, 16'h1234);
      test_random_states(items_sent + 100);
      write_csr(CSR_DISCOUNT, 16'($urandom));
      write_csr(CSR_LEARN_RATE, 16'($urandom_range(0, 8000)));
      write_csr(CSR_TRACE_DECAY, 16'($urandom));
      test_random_states(items_sent + 250);
   endtask

   initial begin
      reset <= 1'b1;
      csr_we <= 1'b0;
      csr_index <= CSR_DISCOUNT;
      csr_wdata <= 16'd0;
      req_valid <= 1'b0;
      req_cmd <= 1'b0;
      req_position <= 3'd0;
      req_scale_value <= 16'sd0;
      req_feature_index <= 12'd0;
      req_reward <= 32'sd0;
      req_terminal <= 1'b0;
      req_last_feature <= 1'b0;
      rsp_stall <= 1'b0;
      idling = 1'b1;
      mismatches = 0;
      failures = 0;
      items_sent = 0;
      gamma_q = DISCOUNT_RST;
      alpha_q = LEARN_RATE_RST;
      falloff_q = TRACE_DECAY_RST;
      foreach (weights[i]) weights[i] = 0;
      foreach (scales[i]) scales[i] = 0;
      foreach (cur_feats[i]) cur_feats[i] = 12'd0;
      cur_len = NUM_FEATURES;
      new_len = 0;
      trace_newest = 0;
      trace_count = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_scale_loads();
      test_directed_states();
      test_random_states(items_sent + 250);
      idling = 1'b0;
      test_random_states(items_sent + 200);
      idling = 1'b1;
      test_register_settings();

      if (failures == 0 && expected_errors.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

   always @(negedge clock) begin
      rsp_stall <= idling && ($urandom_range(99) < 11);
   end

   // Compares each result transaction with the oldest predicted error.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_errors.size() == 0) begin
            failures++;
            mismatches++;
            if (mismatches <= 10) begin
               $display("Unexpected result: error %0d", rsp_value_error);
            end
         end else begin
            if (rsp_value_error !== expected_errors[0]) begin
               failures++;
               mismatches++;
               if (mismatches <= 10) begin
                  $display("error mismatch: expected %0d, got %0d",
                           expected_errors[0], rsp_value_error);
               end
            end
            void'(expected_errors.pop_front());
         end
      end
   end

   initial begin
      #20ms;
      $display("Some tests failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/tdl_pkg.sv
rtl/core/tdl_front.sv
rtl/core/tdl_back.sv
rtl/core/td_lambda_linear_critic_core.sv
tb/td_lambda_linear_critic_core_test.sv
